// ===== hw/rtl/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 hash unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

   localparam int BlockBytes = 64;
   localparam int Rounds     = 64;

   typedef logic [31:0] word_type;

   // controller -> datapath commands
   typedef struct packed {
      logic       load_byte;   // write byte_in at fill pointer
      logic [7:0] byte_in;
      logic [5:0] addr;
      logic       init_hash;   // restore initial hash values
      logic       comp_start;  // load schedule and working vars
      logic       comp_round;  // run one round
      logic [5:0] round;
      logic       comp_fold;   // add working vars into hash
   } dp_cmd_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_COMP  = 7'b0000010,
      ST_PAD   = 7'b0000100,
      ST_LEN   = 7'b0001000,
      ST_FOLD  = 7'b0010000,
      ST_OUT   = 7'b0100000,
      ST_START = 7'b1000000
   } state_type;

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type RoundConst [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [6:0] LenPos  = 7'd56;

   function automatic word_type ror(input word_type v, input int n);
      ror = (v >> n) | (v << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_hash_unit.sv =====
// SHA-256 hash unit top level: controller plus datapath.
// Depends on sha_pkg, sha_control, sha_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Takes one message byte per word; a word that fills the 64-byte block is
// hashed by the single compression round unit (one round per cycle, 64
// rounds) while input waits. The last word adds one-byte-per-cycle padding
// and one or two more compressions, then the digest leaves as eight 32-bit
// words, H0 first. No new input is taken until the digest has been fully
// read out.
module sha256_hash_unit import sha_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic             rsp_word_last
);
   dp_cmd_type cmd;
   logic [2:0] out_idx;
   word_type   hash_out [8];

   sha_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte, .req_byte_present,
      .req_last_byte, .rsp_valid, .rsp_ready, .out_idx, .cmd);

   sha_datapath u_dp (.clock, .cmd, .hash_out);

   assign rsp_digest_word = hash_out[out_idx];
   assign rsp_word_last   = (out_idx == 3'd7);
endmodule
`default_nettype wire

// ===== hw/rtl/sha_datapath.sv =====
// Datapath: block buffer, rolling schedule, working variables, hash state.
// Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_datapath import sha_pkg::*; (
   input  wire logic       clock,
   input  wire dp_cmd_type cmd,
   output word_type        hash_out [8]
);
   // block held as 16 big-endian words, one byte lane written per load
   word_type   block_ff [BlockBytes/4];
   word_type   sched_ff [16];
   word_type   wv_ff [8];
   word_type   hash_ff [8];

   word_type   x15, x2, wcur, s0, s1, wnew, wv_sel, t1, t2;
   word_type   a, b, c, d, e, f, g, h;
   logic [3:0] i0;
   logic [1:0] lane;

   assign lane = ~cmd.addr[1:0];

   always_comb begin
      a = wv_ff[0]; b = wv_ff[1]; c = wv_ff[2]; d = wv_ff[3];
      e = wv_ff[4]; f = wv_ff[5]; g = wv_ff[6]; h = wv_ff[7];
      i0   = cmd.round[3:0];
      x15  = sched_ff[4'(i0 + 4'd1)];
      x2   = sched_ff[4'(i0 + 4'd14)];
      wcur = sched_ff[i0];
      s0   = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
      s1   = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
      wnew = wcur + s0 + sched_ff[4'(i0 + 4'd9)] + s1;
      wv_sel = (cmd.round < 6'd16) ? wcur : wnew;
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + RoundConst[cmd.round] + wv_sel;
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) block_ff[cmd.addr[5:2]][{lane, 3'b000} +: 8] <= cmd.byte_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.comp_start) begin
         for (int k = 0; k < 16; k++) sched_ff[k] <= block_ff[k];
         for (int k = 0; k < 8; k++) wv_ff[k] <= hash_ff[k];
      end else if (cmd.comp_round) begin
         if (cmd.round >= 6'd16) sched_ff[i0] <= wnew;
         wv_ff[7] <= g; wv_ff[6] <= f; wv_ff[5] <= e; wv_ff[4] <= d + t1;
         wv_ff[3] <= c; wv_ff[2] <= b; wv_ff[1] <= a; wv_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_hash) begin
         for (int k = 0; k < 8; k++) hash_ff[k] <= InitHash[k];
      end else if (cmd.comp_fold) begin
         for (int k = 0; k < 8; k++) hash_ff[k] <= hash_ff[k] + wv_ff[k];
      end
   end

   assign hash_out = hash_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/sha_control.sv =====
// Controller: handshakes, fill pointer, length counter, padding and rounds.
// Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_control import sha_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_byte_present,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      out_idx,
   output dp_cmd_type      cmd
);
   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;     // byte pointer within block
   logic [60:0] count_ff, count_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        final_ff, final_in;   // after compression: pad/len/out
   logic        padnext_ff, padnext_in; // second block needed for length
   logic [63:0] bits;

   assign bits      = {count_ff, 3'b000};
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign out_idx   = idx_ff;

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; count_in = count_ff;
      round_in = round_ff; idx_in = idx_ff; final_in = final_ff;
      padnext_in = padnext_ff;
      cmd = '0;
      cmd.addr = fill_ff;
      cmd.round = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_byte_present) begin
                  cmd.load_byte = 1'b1;
                  cmd.byte_in = req_data_byte;
                  fill_in = fill_ff + 6'd1;
                  count_in = count_ff + 61'd1;
               end
               final_in = req_last_byte;
               if (req_byte_present && fill_ff == 6'd63) state_in = ST_START;
               else if (req_last_byte) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            // 0x80 marker after the message
            cmd.load_byte = 1'b1; cmd.byte_in = PadByte;
            fill_in = fill_ff + 6'd1;
            padnext_in = ({1'b0, fill_ff} >= LenPos);
            // marker in the last slot: block is already full
            if (fill_ff == 6'd63) state_in = ST_START;
            else state_in = ST_LEN;
         end
         ST_LEN: begin
            // zero fill, then length bytes, one byte a cycle
            cmd.load_byte = 1'b1;
            if (!padnext_ff && fill_ff >= LenPos[5:0])
               cmd.byte_in = bits[8*(6'd63 - fill_ff) +: 8];
            else
               cmd.byte_in = 8'h00;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) state_in = ST_START;
         end
         ST_START: begin
            cmd.comp_start = 1'b1; round_in = '0; state_in = ST_COMP;
         end
         ST_COMP: begin
            cmd.comp_round = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(Rounds - 1)) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.comp_fold = 1'b1;
            if (!final_ff) state_in = ST_IDLE;
            else if (padnext_ff) begin
               padnext_in = 1'b0; state_in = ST_LEN;
            end else begin
               idx_in = '0; state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.init_hash = 1'b1;
                  count_in = '0; fill_in = '0; final_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // hash state starts from the initial values
      if (reset) begin
         cmd = '0;
         cmd.init_hash = 1'b1;
      end
   end

   // full block on the last byte: still has to pad afterwards
   logic pad_after_ff, pad_after_in;
   always_comb begin
      pad_after_in = pad_after_ff;
      if (state_ff == ST_IDLE && req_valid)
         pad_after_in = req_byte_present && fill_ff == 6'd63 && req_last_byte;
      else if (state_ff == ST_FOLD) pad_after_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; fill_ff <= '0; count_ff <= '0; round_ff <= '0;
         idx_ff <= '0; final_ff <= 1'b0; padnext_ff <= 1'b0; pad_after_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in; count_ff <= count_in; round_ff <= round_in;
         idx_ff <= idx_in; padnext_ff <= padnext_in; pad_after_ff <= pad_after_in;
         if (state_ff == ST_FOLD && pad_after_ff) begin
            state_ff <= ST_PAD; final_ff <= 1'b1;
         end else begin
            state_ff <= state_in; final_ff <= final_in;
         end
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/sha_checker.sv =====
// Port-level checks for the SHA-256 hash unit, bound to the top level.
// Depends on sha256_hash_unit.
`timescale 1ns / 1ps
`default_nettype none
module sha_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic        rsp_word_last
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("input open while digest pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word))
      else $error("digest word changed under stall");
   a_last_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_word_last |=> !rsp_valid)
      else $error("output continued after last word");
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("output valid after reset");
endmodule

bind sha256_hash_unit sha_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_digest_word, .rsp_word_last);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking bench for sha256_hash_unit: byte words in, digest words out.
// Depends on sha_pkg and the sha256_hash_unit RTL.
`timescale 1ns / 1ps
module testbench;
   import sha_pkg::*;

   localparam int WatchLimit = 20000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last_byte;
   } byte_word_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        word_last;
   } digest_out_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 0;
   logic        req_byte_present = 0;
   logic        req_last_byte = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_digest_word;
   logic        rsp_word_last;

   sha256_hash_unit DUT (.*);

   always #5 clock = ~clock;

   // predictor state
   word_type    hash_state [8];
   logic [7:0]  msg_block [64];
   int unsigned block_fill;
   logic [60:0] msg_len;

   byte_word_type  pending_bytes [$];
   digest_out_type expected_digest [$];
   int  error_count = 0;
   int  send_idle_pct = 10;
   int  recv_idle_pct = 70;
   int  recv_hold = 0;
   bit  send_pause = 0;
   bit  stim_done = 0;
   bit  req_taken = 0;
   int  idle_cycles = 0;
   int  digests_seen = 0;

   function automatic word_type rotr(word_type v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic void compress();
      word_type w [16];
      word_type a, b, c, d, e, f, g, h, t1, t2, wv, x15, x2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
      {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
      for (int i = 0; i < 64; i++) begin
         if (i < 16) wv = w[i];
         else begin
            x15 = w[(i - 15) & 15];
            x2 = w[(i - 2) & 15];
            wv = w[i & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                 + w[(i - 7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
            w[i & 15] = wv;
         end
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + RoundConst[i] + wv;
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endfunction

   function automatic void restart_message();
      hash_state = InitHash;
      block_fill = 0;
      msg_len = 0;
   endfunction

   function automatic void predict_digest(byte_word_type wd);
      logic [63:0] bit_len;
      if (wd.byte_present) begin
         msg_block[block_fill] = wd.data_byte;
         block_fill++;
         msg_len++;
         if (block_fill == 64) begin
            compress();
            block_fill = 0;
         end
      end
      if (!wd.last_byte) return;
      bit_len = {msg_len, 3'b000};
      msg_block[block_fill] = PadByte;
      block_fill++;
      if (block_fill > 56) begin
         for (int i = block_fill; i < 64; i++) msg_block[i] = 0;
         compress();
         block_fill = 0;
      end
      for (int i = block_fill; i < 56; i++) msg_block[i] = 0;
      for (int i = 0; i < 8; i++) msg_block[63 - i] = bit_len[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) expected_digest.push_back('{hash_state[i], i == 7});
      restart_message();
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void queue_message(int len);
      for (int i = 0; i < len; i++)
         pending_bytes.push_back('{8'($urandom), 1'b1, 1'b0});
      if (len > 0 && $urandom_range(1, 0)) pending_bytes[$].last_byte = 1;
      else pending_bytes.push_back('{8'($urandom), 1'b0, 1'b1});
   endfunction

   // driver: next word once the current one was taken at the last rising edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_bytes.size() > 0 && !send_pause
                && $urandom_range(99, 0) >= send_idle_pct) begin
               {req_data_byte, req_byte_present, req_last_byte} = pending_bytes.pop_front();
               req_valid <= 1;
            end else
               req_valid <= 0;
         end
      end
   end

   // receiver: random back-pressure plus an occasional long hold
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready <= 0;
         end else
            rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         req_taken = req_valid && req_ready;
         if (req_taken)
            predict_digest('{req_data_byte, req_byte_present, req_last_byte});
         if (rsp_valid && rsp_ready) begin
            if (expected_digest.size() == 0) begin
               report_mismatch("unexpected digest word", rsp_digest_word, 0);
            end else begin
               digest_out_type want;
               want = expected_digest.pop_front();
               if (rsp_digest_word !== want.digest_word)
                  report_mismatch("digest_word", rsp_digest_word, want.digest_word);
               if (rsp_word_last !== want.word_last)
                  report_mismatch("word_last", rsp_word_last, want.word_last);
               if (rsp_word_last) digests_seen++;
            end
         end
         if ((rsp_valid && rsp_ready) || req_taken) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WatchLimit) begin
            $display("timeout: no handshake for %0d cycles", WatchLimit);
            $display("sha256_hash_unit test failed");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_bytes.size() > 0 || req_valid || expected_digest.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      restart_message();
      for (int i = 0; i < 64; i++) msg_block[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: empty, byte edge values, idle words, block boundaries
      pending_bytes.push_back('{8'h00, 1'b0, 1'b1});
      pending_bytes.push_back('{8'hff, 1'b0, 1'b0});
      pending_bytes.push_back('{8'h00, 1'b1, 1'b1});
      pending_bytes.push_back('{8'hff, 1'b1, 1'b0});
      pending_bytes.push_back('{8'h5a, 1'b0, 1'b0});
      pending_bytes.push_back('{8'ha5, 1'b1, 1'b1});
      drain();
      queue_message(55);
      queue_message(56);
      queue_message(64);
      drain();

      // sender pauses until all digests are back, then a long receiver stall
      send_pause = 1;
      drain();
      send_pause = 0;
      recv_hold = 600;
      for (int m = 0; m < 3; m++) queue_message($urandom_range(5, 0));
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         int sent;
         send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 70 : 0;
         recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 10 : 0;
         sent = 0;
         while (sent < 90) begin
            int len;
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(130, 0)
                                               : $urandom_range(20, 0);
            queue_message(len);
            if ($urandom_range(3, 0) == 0)
               pending_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
            sent += len + 1;
         end
         drain();
      end

      $display("covered %0d digests: empty, padding edges at 55/56/64 bytes,", digests_seen);
      $display("multi-block messages, idle words and long input/output stalls");
      if (error_count == 0)
         $display("sha256_hash_unit test passed");
      else
         $display("sha256_hash_unit test failed");
      $finish;
   end
endmodule
